### rtl/core/lms_adaptive_fir_sysid_unit_macros.svh
// Assertion macros shared by the LMS system identification RTL.
`ifndef LMS_ADAPTIVE_FIR_SYSID_UNIT_MACROS_SVH
`define LMS_ADAPTIVE_FIR_SYSID_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low.
`define LMSID_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, quiet while rst_n is low.
`define LMSID_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/lmsid_pkg.sv
// Types and fixed-point constants for the LMS system identification block.
package lmsid_pkg;

    localparam int SAMPLE_W = 16;   // excitation, response, drive, output
    localparam int ERR_W    = 17;   // response minus output
    localparam int WEIGHT_W = 40;   // signed Q8.32
    localparam int SHIFT_W  = 5;
    localparam int ACC_W    = 64;   // saturating accumulator
    localparam int OPB_W    = 17;   // second multiplier operand
    localparam int PROD_W   = WEIGHT_W + OPB_W;
    localparam int INC_W    = 32;   // error * tap always fits 32 bits signed

    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd8;

    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_FILT   = 7'b0000100,
        ST_CALC   = 7'b0001000,
        ST_ERR    = 7'b0010000,
        ST_UPD    = 7'b0100000,
        ST_FINISH = 7'b1000000
    } state_t;

endpackage

### rtl/core/lmsid_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lmsid_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/lms_adaptive_fir_sysid_unit.sv
// Top level: LMS adaptive FIR for system identification, one shared multiplier.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------------------
//  in      | in        | in_valid / in_stall   | excitation_sample, response_sample
//  out     | out       | out_valid / out_stall | drive_sample, model_output, error_value
//  cfg     | in        | cfg_valid / cfg_ready | update_shift
//
//  A transfer gives its result after both walks; the next transfer is taken only once the
//  result is loaded. One 40x17 multiplier walks every tap for the filter sum and again for
//  the weight update, with the tap pipeline drained after each walk, plus one step each
//  for the output, the error and the result load.
//  After reset a clearing pass zeroes both RAMs; in_stall is high.
//  in_stall is high while an item is in work; a held out_stall only delays the end of the
//  item that follows. cfg_ready is always high; write only while the block is idle.
module lms_adaptive_fir_sysid_unit #(
    parameter int TAP_COUNT = 256
) (
    input  logic                                     clk,
    input  logic                                     rst_n,

    input  logic                                     in_valid,
    output logic                                     in_stall,
    input  logic signed [lmsid_pkg::SAMPLE_W-1:0]    excitation_sample,
    input  logic signed [lmsid_pkg::SAMPLE_W-1:0]    response_sample,

    output logic                                     out_valid,
    input  logic                                     out_stall,
    output logic signed [lmsid_pkg::SAMPLE_W-1:0]    drive_sample,
    output logic signed [lmsid_pkg::SAMPLE_W-1:0]    model_output,
    output logic signed [lmsid_pkg::ERR_W-1:0]       error_value,

    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [lmsid_pkg::SHIFT_W-1:0]            update_shift
);

    // Address and counter widths; the counter must reach TAP_COUNT itself.
    localparam int AW = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
    localparam int CW = $clog2(TAP_COUNT + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(TAP_COUNT - 1);
    localparam logic [CW-1:0] CNT_LAST  = CW'(TAP_COUNT - 1);
    localparam logic [CW-1:0] CNT_END   = CW'(TAP_COUNT);

    localparam int SW = lmsid_pkg::SAMPLE_W;
    localparam int WW = lmsid_pkg::WEIGHT_W;
    localparam int EW = lmsid_pkg::ERR_W;
    localparam int BW = lmsid_pkg::OPB_W;
    localparam int PW = lmsid_pkg::PROD_W;
    localparam int AC = lmsid_pkg::ACC_W;
    localparam int IW = lmsid_pkg::INC_W;

    localparam logic signed [SW-1:0] Y_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] Y_MIN = {1'b1, {(SW-1){1'b0}}};
    localparam logic signed [AC-1:0] ACC_MAX = {1'b0, {(AC-1){1'b1}}};
    localparam logic signed [AC-1:0] ACC_MIN = {1'b1, {(AC-1){1'b0}}};
    localparam logic signed [WW-1:0] W_MAX = {1'b0, {(WW-1){1'b1}}};
    localparam logic signed [WW-1:0] W_MIN = {1'b1, {(WW-1){1'b0}}};

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    lmsid_pkg::state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;        // tap issue count, also clear sweep
    logic [AW-1:0] tap_ptr_reg, tap_ptr_next; // circular read pointer of the delay line
    logic [AW-1:0] head_reg, head_next;       // address of the newest sample (tap 0)
    logic [lmsid_pkg::SHIFT_W-1:0] update_shift_reg;

    // Item payload held across the two walks
    logic signed [SW-1:0] x_reg, d_reg, y_reg;
    logic signed [EW-1:0] e_reg;
    logic signed [AC-1:0] acc_reg;

    // Tap pipeline: read issue -> multiply -> shift -> write back
    logic          v1_reg, v2_reg, v3_reg;
    logic [AW-1:0] a1_reg, a2_reg, a3_reg;
    logic signed [WW-1:0] w2_reg, w3_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [IW-1:0] inc_reg;

    // Output register
    logic                 out_valid_reg;
    logic signed [SW-1:0] drive_reg, model_reg;
    logic signed [EW-1:0] error_reg;

    // ------------------------------------------------------------------
    // Combinational control
    // ------------------------------------------------------------------
    logic          accept;
    logic          walking;
    logic          issue;
    logic          drained;
    logic          out_free;
    logic [AW-1:0] head_dec;
    logic [AW-1:0] ptr_inc;

    assign in_stall  = (state_reg != lmsid_pkg::ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign walking   = (state_reg == lmsid_pkg::ST_FILT) || (state_reg == lmsid_pkg::ST_UPD);
    assign issue     = walking && (cnt_reg != CNT_END);
    assign drained   = !v1_reg && !v2_reg && !v3_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign head_dec  = (head_reg == '0) ? LAST_ADDR : head_reg - 1'b1;
    assign ptr_inc   = (tap_ptr_reg == LAST_ADDR) ? '0 : tap_ptr_reg + 1'b1;

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        tap_ptr_next = tap_ptr_reg;
        head_next    = head_reg;
        case (state_reg)
            lmsid_pkg::ST_CLEAR:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    cnt_next   = '0;
                    state_next = lmsid_pkg::ST_IDLE;
                end
            end
            lmsid_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    // new sample becomes tap 0, older ones move one place along
                    head_next    = head_dec;
                    tap_ptr_next = head_dec;
                    cnt_next     = '0;
                    state_next   = lmsid_pkg::ST_FILT;
                end
            end
            lmsid_pkg::ST_FILT:
            begin
                if (issue)
                begin
                    cnt_next     = cnt_reg + 1'b1;
                    tap_ptr_next = ptr_inc;
                end
                else if (drained)
                begin
                    state_next = lmsid_pkg::ST_CALC;
                end
            end
            lmsid_pkg::ST_CALC:
            begin
                state_next = lmsid_pkg::ST_ERR;
            end
            lmsid_pkg::ST_ERR:
            begin
                cnt_next     = '0;
                tap_ptr_next = head_reg;
                state_next   = lmsid_pkg::ST_UPD;
            end
            lmsid_pkg::ST_UPD:
            begin
                if (issue)
                begin
                    cnt_next     = cnt_reg + 1'b1;
                    tap_ptr_next = ptr_inc;
                end
                else if (drained)
                begin
                    state_next = lmsid_pkg::ST_FINISH;
                end
            end
            lmsid_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = lmsid_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lmsid_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Delay line and weight RAMs
    // ------------------------------------------------------------------
    logic                 clearing;
    logic                 tap_we;
    logic [AW-1:0]        tap_waddr;
    logic [SW-1:0]        tap_wdata;
    logic [SW-1:0]        tap_rdata;
    logic signed [SW-1:0] tap_rd;

    logic                 wt_we;
    logic [AW-1:0]        wt_waddr;
    logic [WW-1:0]        wt_wdata;
    logic [WW-1:0]        wt_rdata;
    logic signed [WW-1:0] wt_rd;
    logic signed [WW-1:0] w_sat;

    assign clearing  = (state_reg == lmsid_pkg::ST_CLEAR);
    assign tap_we    = clearing || accept;
    assign tap_waddr = clearing ? cnt_reg[AW-1:0] : head_dec;
    assign tap_wdata = clearing ? '0 : excitation_sample;
    assign tap_rd    = $signed(tap_rdata);

    assign wt_we    = clearing || ((state_reg == lmsid_pkg::ST_UPD) && v3_reg);
    assign wt_waddr = clearing ? cnt_reg[AW-1:0] : a3_reg;
    assign wt_wdata = clearing ? '0 : w_sat;
    assign wt_rd    = $signed(wt_rdata);

    lmsid_ram #(
        .WIDTH (SW),
        .DEPTH (TAP_COUNT)
    ) u_tap_ram (
        .clk   (clk),
        .we    (tap_we),
        .waddr (tap_waddr),
        .wdata (tap_wdata),
        .raddr (tap_ptr_reg),
        .rdata (tap_rdata)
    );

    lmsid_ram #(
        .WIDTH (WW),
        .DEPTH (TAP_COUNT)
    ) u_wt_ram (
        .clk   (clk),
        .we    (wt_we),
        .waddr (wt_waddr),
        .wdata (wt_wdata),
        .raddr (cnt_reg[AW-1:0]),
        .rdata (wt_rdata)
    );

    // ------------------------------------------------------------------
    // Shared multiplier
    //   filter walk: weight x tap         (Q8.32 x int -> Q.32)
    //   update walk: tap x error          (int x int)
    // ------------------------------------------------------------------
    logic signed [WW-1:0] op_a;
    logic signed [BW-1:0] op_b;
    logic signed [PW-1:0] mul;

    always_comb
    begin
        if (state_reg == lmsid_pkg::ST_FILT)
        begin
            op_a = wt_rd;
            op_b = $signed({{(BW-SW){tap_rd[SW-1]}}, tap_rd});
        end
        else
        begin
            op_a = $signed({{(WW-SW){tap_rd[SW-1]}}, tap_rd});
            op_b = e_reg;
        end
    end

    assign mul = op_a * op_b;

    // Saturating accumulate at the signed 64-bit limits
    logic signed [AC:0]   acc_sum;
    logic signed [AC-1:0] acc_sat;

    assign acc_sum = $signed({acc_reg[AC-1], acc_reg})
                   + $signed({{(AC+1-PW){prod_reg[PW-1]}}, prod_reg});
    always_comb
    begin
        if (acc_sum[AC] != acc_sum[AC-1])
        begin
            acc_sat = acc_sum[AC] ? ACC_MIN : ACC_MAX;
        end
        else
        begin
            acc_sat = acc_sum[AC-1:0];
        end
    end

    // Output: floor(acc / 2^32), saturated to 16 bits
    logic                 acc_hi_fits;
    logic signed [SW-1:0] y_calc;

    assign acc_hi_fits = (&acc_reg[AC-1:32+SW-1]) || !(|acc_reg[AC-1:32+SW-1]);
    assign y_calc      = acc_hi_fits ? acc_reg[32+SW-1:32] : (acc_reg[AC-1] ? Y_MIN : Y_MAX);

    // Weight update with saturation to 40 bits
    logic signed [WW:0] w_sum;

    assign w_sum = $signed({w3_reg[WW-1], w3_reg})
                 + $signed({{(WW+1-IW){inc_reg[IW-1]}}, inc_reg});
    always_comb
    begin
        if (w_sum[WW] != w_sum[WW-1])
        begin
            w_sat = w_sum[WW] ? W_MIN : W_MAX;
        end
        else
        begin
            w_sat = w_sum[WW-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= lmsid_pkg::ST_CLEAR;
            cnt_reg          <= '0;
            tap_ptr_reg      <= '0;
            head_reg         <= '0;
            update_shift_reg <= lmsid_pkg::SHIFT_RESET;
            v1_reg           <= 1'b0;
            v2_reg           <= 1'b0;
            v3_reg           <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            tap_ptr_reg <= tap_ptr_next;
            head_reg    <= head_next;
            if (cfg_valid && cfg_ready)
            begin
                update_shift_reg <= update_shift;
            end
            v1_reg <= issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg && (state_reg == lmsid_pkg::ST_UPD);
            if ((state_reg == lmsid_pkg::ST_FINISH) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath: no reset needed
    always_ff @(posedge clk)
    begin
        a1_reg   <= cnt_reg[AW-1:0];
        a2_reg   <= a1_reg;
        a3_reg   <= a2_reg;
        w2_reg   <= wt_rd;
        w3_reg   <= w2_reg;
        prod_reg <= mul;
        inc_reg  <= $signed(prod_reg[IW-1:0]) >>> update_shift_reg;

        if (accept)
        begin
            x_reg   <= excitation_sample;
            d_reg   <= response_sample;
            acc_reg <= '0;
        end
        else if ((state_reg == lmsid_pkg::ST_FILT) && v2_reg)
        begin
            acc_reg <= acc_sat;
        end

        if (state_reg == lmsid_pkg::ST_CALC)
        begin
            y_reg <= y_calc;
        end
        if (state_reg == lmsid_pkg::ST_ERR)
        begin
            e_reg <= $signed({d_reg[SW-1], d_reg}) - $signed({y_reg[SW-1], y_reg});
        end

        if ((state_reg == lmsid_pkg::ST_FINISH) && out_free)
        begin
            drive_reg <= x_reg;
            model_reg <= y_reg;
            error_reg <= e_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign drive_sample = drive_reg;
    assign model_output = model_reg;
    assign error_value  = error_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`include "lms_adaptive_fir_sysid_unit_macros.svh"

    `LMSID_ASSERT_IMPL(a_calc_drained,
        state_reg == lmsid_pkg::ST_CALC, drained,
        "filter walk left taps in flight")
    `LMSID_ASSERT_IMPL(a_wt_write_phase,
        wt_we, clearing || state_reg == lmsid_pkg::ST_UPD,
        "weight write outside clear or update")
    `LMSID_ASSERT_NEXT(a_transfer_starts,
        accept, state_reg == lmsid_pkg::ST_FILT && cnt_reg == '0,
        "transfer did not start filter walk")
    `LMSID_ASSERT_IMPL(a_cnt_bound,
        walking, cnt_reg <= CNT_END,
        "tap count beyond tap total")

endmodule
